>>> rtl/white_blob_column_steer_macros.svh
// Assertion macros for the white blob column steering block.
// Used by the controller; no other dependencies.
`ifndef WHITE_BLOB_COLUMN_STEER_MACROS_SVH
`define WHITE_BLOB_COLUMN_STEER_MACROS_SVH

`ifndef SYNTH
`define WBCS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define WBCS_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define WBCS_ASSERT(label, clk, rst_n, prop, msg)
`define WBCS_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

>>> rtl/wbcs_pkg.sv
// Shared types, constants and helper functions for the white blob column steering block.
// No dependencies.
`default_nettype none

package wbcs_pkg;

	localparam int unsigned MAX_FRAME_PIXELS_DEF = 4194303;
	localparam int unsigned COUNT_HW_MAX         = 4194303;

	localparam int WIDTH_W = 12;
	localparam int COUNT_W = 22;
	localparam int SUM_W   = 34;
	localparam int CHAN_W  = 8;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [CHAN_W-1:0]  WHITE_LEVEL   = 8'hFF;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET   = 12'd640;
	// floor(x/3) = (x * 2731) >> 13 for all x below 8192
	localparam logic [WIDTH_W-1:0] THIRD_RECIP   = 12'd2731;
	localparam int                 THIRD_SHIFT   = 13;

	localparam logic [APB_AW-1:0]  REG_IMAGE_WIDTH = 3'd0;

	typedef enum logic [1:0] {
		STEER_STOP  = 2'd0,
		STEER_LEFT  = 2'd1,
		STEER_FWD   = 2'd2,
		STEER_RIGHT = 2'd3
	} steer_t;

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_THRESH,
		ST_MULT,
		ST_DECIDE
	} ctrl_state_t;

	typedef struct packed {
		logic pix_accept;
		logic calc_thresh;
		logic calc_prod;
		logic load_out;
	} dp_cmd_t;

	function automatic logic [WIDTH_W-1:0] third_floor(input logic [WIDTH_W:0] x);
		logic [WIDTH_W+WIDTH_W:0] prod;
		prod = x * THIRD_RECIP;
		return prod[THIRD_SHIFT +: WIDTH_W];
	endfunction

endpackage

`default_nettype wire

>>> rtl/wbcs_cfg.sv
// APB-style configuration register file: holds the image width.
// Depends on wbcs_pkg.
`default_nettype none

module wbcs_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [wbcs_pkg::APB_AW-1:0]   paddr,
	input  wire logic [wbcs_pkg::APB_DW-1:0]   pwdata,
	output logic      [wbcs_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	output logic      [wbcs_pkg::WIDTH_W-1:0]  row_width
);
	import wbcs_pkg::*;

	logic [WIDTH_W-1:0] width_q;
	logic               hit_width;
	logic               wr_en;

	assign hit_width = ({paddr[APB_AW-1:2], 2'b00} == REG_IMAGE_WIDTH);
	assign wr_en     = psel & penable & pwrite & pready;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (wr_en && hit_width) begin
			width_q <= pwdata[WIDTH_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit_width) begin
			prdata = {{(APB_DW-WIDTH_W){1'b0}}, width_q};
		end
	end

	assign row_width = width_q;

endmodule

`default_nettype wire

>>> rtl/wbcs_datapath.sv
// Datapath: column tracking, white pixel accumulation, thresholds, products,
// steering decision and output registers. Depends on wbcs_pkg.
`default_nettype none

module wbcs_datapath #(
	parameter int unsigned MAX_FRAME_PIXELS = wbcs_pkg::MAX_FRAME_PIXELS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire wbcs_pkg::dp_cmd_t             cmd,
	input  wire logic [wbcs_pkg::WIDTH_W-1:0]  row_width,
	input  wire logic [wbcs_pkg::CHAN_W-1:0]   red,
	input  wire logic [wbcs_pkg::CHAN_W-1:0]   green,
	input  wire logic [wbcs_pkg::CHAN_W-1:0]   blue,
	input  wire logic                          end_of_frame,
	output logic      [1:0]                    steer_command,
	output logic      [wbcs_pkg::COUNT_W-1:0]  white_count
);
	import wbcs_pkg::*;

	localparam int unsigned LIMIT_INT =
		(MAX_FRAME_PIXELS < COUNT_HW_MAX) ? MAX_FRAME_PIXELS : COUNT_HW_MAX;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = LIMIT_INT[COUNT_W-1:0];

	logic [WIDTH_W-1:0] col_q;
	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]   snap_sum_q;
	logic [COUNT_W-1:0] snap_cnt_q;
	logic [WIDTH_W-1:0] t_left_q;
	logic [WIDTH_W-1:0] t_right_q;
	logic [SUM_W-1:0]   prod_left_q;
	logic [SUM_W-1:0]   prod_right_q;
	steer_t             command_q;
	logic [COUNT_W-1:0] count_q;

	logic               hit;
	logic [COUNT_W-1:0] cnt_nxt;
	logic [SUM_W:0]     sum_add;
	logic [SUM_W-1:0]   sum_nxt;
	logic [WIDTH_W:0]   col_inc;
	logic [WIDTH_W-1:0] col_nxt;
	steer_t             command_nxt;

	assign hit = (red == WHITE_LEVEL) && (green == WHITE_LEVEL) && (blue == WHITE_LEVEL)
		&& (cnt_q < COUNT_LIMIT);

	always_comb begin
		cnt_nxt = cnt_q;
		sum_nxt = sum_q;
		sum_add = {1'b0, sum_q} + {{(SUM_W+1-WIDTH_W){1'b0}}, col_q};
		if (hit) begin
			cnt_nxt = cnt_q + {{(COUNT_W-1){1'b0}}, 1'b1};
			sum_nxt = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
		end
		col_inc = {1'b0, col_q} + {{WIDTH_W{1'b0}}, 1'b1};
		col_nxt = (col_inc >= {1'b0, row_width}) ? '0 : col_inc[WIDTH_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.pix_accept) begin
			if (end_of_frame) begin
				col_q <= '0;
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				col_q <= col_nxt;
				sum_q <= sum_nxt;
				cnt_q <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_accept && end_of_frame) begin
			snap_sum_q <= sum_nxt;
			snap_cnt_q <= cnt_nxt;
		end
		if (cmd.calc_thresh) begin
			t_left_q  <= third_floor({1'b0, row_width});
			t_right_q <= third_floor({row_width, 1'b0}) + {{(WIDTH_W-1){1'b0}}, 1'b1};
		end
		if (cmd.calc_prod) begin
			prod_left_q  <= t_left_q * snap_cnt_q;
			prod_right_q <= t_right_q * snap_cnt_q;
		end
		if (cmd.load_out) begin
			command_q <= command_nxt;
			count_q   <= snap_cnt_q;
		end
	end

	// mean < t  <=>  sum < t*cnt ; mean > t2  <=>  sum >= (t2+1)*cnt
	always_comb begin
		if (snap_cnt_q == '0) begin
			command_nxt = STEER_STOP;
		end else if (snap_sum_q < prod_left_q) begin
			command_nxt = STEER_LEFT;
		end else if (snap_sum_q >= prod_right_q) begin
			command_nxt = STEER_RIGHT;
		end else begin
			command_nxt = STEER_FWD;
		end
	end

	assign steer_command = command_q;
	assign white_count   = count_q;

endmodule

`default_nettype wire

>>> rtl/wbcs_ctrl.sv
// Controller state machine: pixel handshake, end-of-frame decision sequence
// and output beat handshake. Depends on wbcs_pkg and the assertion macros.
`default_nettype none
`include "white_blob_column_steer_macros.svh"

module wbcs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               pixel_valid,
	input  wire logic               end_of_frame,
	output logic                    pixel_stall,
	output logic                    steer_valid,
	input  wire logic               steer_stall,
	output wbcs_pkg::dp_cmd_t       cmd
);
	import wbcs_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        out_valid_q;
	logic        out_free;
	logic        pix_take;

	assign out_free = !out_valid_q || !steer_stall;
	assign pix_take = pixel_valid && (state_q == ST_ACCUM);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_ACCUM: begin
				if (pix_take && end_of_frame) begin
					state_nxt = ST_THRESH;
				end
			end
			ST_THRESH: state_nxt = ST_MULT;
			ST_MULT:   state_nxt = ST_DECIDE;
			ST_DECIDE: begin
				if (out_free) begin
					state_nxt = ST_ACCUM;
				end
			end
			default:   state_nxt = ST_ACCUM;
		endcase
	end

	always_comb begin
		cmd         = '0;
		pixel_stall = 1'b1;
		case (state_q)
			ST_ACCUM: begin
				pixel_stall    = 1'b0;
				cmd.pix_accept = pix_take;
			end
			ST_THRESH: cmd.calc_thresh = 1'b1;
			ST_MULT:   cmd.calc_prod   = 1'b1;
			ST_DECIDE: cmd.load_out    = out_free;
			default:   cmd             = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCUM;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			out_valid_q <= cmd.load_out || (out_valid_q && steer_stall);
		end
	end

	assign steer_valid = out_valid_q;

	`WBCS_ASSERT(a_eof_starts_calc, clk, arst_n, (pixel_valid && !pixel_stall && end_of_frame) |=> (state_q == ST_THRESH), "end-of-frame beat did not start decision")
	`WBCS_ASSERT(a_hold_when_blocked, clk, arst_n, (state_q == ST_DECIDE && out_valid_q && steer_stall) |=> (state_q == ST_DECIDE && out_valid_q), "decision advanced over a stalled result")
	`WBCS_ASSERT(a_result_from_decide, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_DECIDE), "result beat raised outside decision step")
	`WBCS_NEVER(a_no_pixel_in_calc, clk, arst_n, cmd.pix_accept && (state_q != ST_ACCUM), "pixel taken during decision")

endmodule

`default_nettype wire

>>> rtl/white_blob_column_steer.sv
// White blob column steering, top level.
// Pixel channel: red/green/blue/end_of_frame with pixel_valid, pixel_stall.
// A beat is taken at a rising edge with valid high and stall low.
// Result channel: steer_command/white_count with steer_valid, steer_stall;
// one result beat per frame, on the beat marked end_of_frame.
// Throughput: one pixel per cycle inside a frame. After the end-of-frame beat
// come the threshold, product and compare steps, during which pixel_stall is high;
// the compare step raises the result beat once the result register is free.
// The mean column is never divided out: the sum is compared against the two
// thresholds times the count, each product taken from its own 12x22 multiplier.
// Receiver stall: the result register holds; pixels keep flowing until the next
// frame end, whose decision waits until the held result is taken.
// Reset: accumulators and column clear, no result pending, row width is 640.
// Config: row width at byte address 0 over the APB-style port, to be written
// by the user only while idle (not enforced); it takes effect at the next pixel.
// Depends on wbcs_pkg, wbcs_cfg, wbcs_ctrl, wbcs_datapath.
`default_nettype none

module white_blob_column_steer #(
	parameter int unsigned MAX_FRAME_PIXELS = wbcs_pkg::MAX_FRAME_PIXELS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [wbcs_pkg::APB_AW-1:0]   paddr,
	input  wire logic [wbcs_pkg::APB_DW-1:0]   pwdata,
	output logic      [wbcs_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	input  wire logic                          pixel_valid,
	output logic                               pixel_stall,
	input  wire logic [wbcs_pkg::CHAN_W-1:0]   red,
	input  wire logic [wbcs_pkg::CHAN_W-1:0]   green,
	input  wire logic [wbcs_pkg::CHAN_W-1:0]   blue,
	input  wire logic                          end_of_frame,
	output logic                               steer_valid,
	input  wire logic                          steer_stall,
	output logic      [1:0]                    steer_command,
	output logic      [wbcs_pkg::COUNT_W-1:0]  white_count
);
	import wbcs_pkg::*;

	logic [WIDTH_W-1:0] row_width;
	dp_cmd_t            cmd;

	wbcs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.row_width (row_width)
	);

	wbcs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.end_of_frame (end_of_frame),
		.pixel_stall  (pixel_stall),
		.steer_valid  (steer_valid),
		.steer_stall  (steer_stall),
		.cmd          (cmd)
	);

	wbcs_datapath #(
		.MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.row_width     (row_width),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.end_of_frame  (end_of_frame),
		.steer_command (steer_command),
		.white_count   (white_count)
	);

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking bench for white_blob_column_steer: directed frames, then random
// pixel frames under bursty input and a patterned result stall, checked per beat.
// Depends on wbcs_pkg and the white_blob_column_steer RTL.
`timescale 1ns / 100ps

module testbench;
	import wbcs_pkg::*;

	localparam logic [APB_AW-1:0] SPARE_REG_ADDR = 3'd4;
	localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_HW_MAX);
	localparam logic [SUM_W-1:0] SUM_CAP = {SUM_W{1'b1}};
	localparam int RANDOM_BEATS = 1090;
	localparam int DRAIN_LIMIT = 40000;

	typedef struct {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic eof;
	} pixel_t;

	typedef struct {
		steer_t cmd;
		logic [COUNT_W-1:0] count;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic pixel_valid = 1'b0;
	logic pixel_stall;
	logic [CHAN_W-1:0] red = '0;
	logic [CHAN_W-1:0] green = '0;
	logic [CHAN_W-1:0] blue = '0;
	logic end_of_frame = 1'b0;
	logic steer_valid;
	logic steer_stall = 1'b0;
	logic [1:0] steer_command;
	logic [COUNT_W-1:0] white_count;

	pixel_t pixel_q[$];
	verdict_t verdict_q[$];
	pixel_t cur_pixel;
	int queued_beats = 0;
	int mismatches = 0;

	logic [WIDTH_W-1:0] cfg_width = WIDTH_RESET;
	logic [WIDTH_W-1:0] col_pos = '0;
	logic [SUM_W-1:0] col_sum = '0;
	logic [COUNT_W-1:0] white_cnt = '0;

	int gap_left = 0;
	int burst_left = 0;

	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int stall_tick = 0;

	white_blob_column_steer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.end_of_frame(end_of_frame),
		.steer_valid(steer_valid),
		.steer_stall(steer_stall),
		.steer_command(steer_command),
		.white_count(white_count)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic steer_t steer_for(input logic [SUM_W-1:0] sum,
			input logic [COUNT_W-1:0] cnt, input logic [WIDTH_W-1:0] w);
		longint unsigned s;
		longint unsigned c;
		longint unsigned wl;
		longint unsigned mean;
		if (cnt == 0) return STEER_STOP;
		s = sum;
		c = cnt;
		wl = w;
		mean = s / c;
		if (mean < wl / 3) return STEER_LEFT;
		if (mean > (2 * wl) / 3) return STEER_RIGHT;
		return STEER_FWD;
	endfunction

	task automatic track_pixel(input pixel_t p);
		logic [SUM_W:0] wide_sum;
		logic [WIDTH_W:0] nxt;
		verdict_t v;
		if (p.red == WHITE_LEVEL && p.green == WHITE_LEVEL && p.blue == WHITE_LEVEL
				&& white_cnt < COUNT_CAP) begin
			white_cnt = white_cnt + 1'b1;
			wide_sum = {1'b0, col_sum} + col_pos;
			col_sum = (wide_sum > {1'b0, SUM_CAP}) ? SUM_CAP : wide_sum[SUM_W-1:0];
		end
		nxt = col_pos + 1'b1;
		if (nxt >= {1'b0, cfg_width}) nxt = '0;
		col_pos = nxt[WIDTH_W-1:0];
		if (p.eof) begin
			v.cmd = steer_for(col_sum, white_cnt, cfg_width);
			v.count = white_cnt;
			verdict_q.push_back(v);
			col_pos = '0;
			col_sum = '0;
			white_cnt = '0;
		end
	endtask

	task automatic flag_mismatch(input string what, input longint exp_v, input longint got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $time);
	endtask

	// feed the pixel channel in bursts with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
		end else if (!pixel_valid || !pixel_stall) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				pixel_valid <= 1'b0;
			end else if (pixel_q.size() > 0) begin
				cur_pixel = pixel_q.pop_front();
				red <= cur_pixel.red;
				green <= cur_pixel.green;
				blue <= cur_pixel.blue;
				end_of_frame <= cur_pixel.eof;
				pixel_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 48);
					gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				pixel_valid <= 1'b0;
			end
		end
	end

	// stall the result channel on a changing pattern, once for a long stretch
	always @(posedge clk) begin
		if (!arst_n) begin
			steer_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			steer_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			steer_stall <= 1'b1;
		end else begin
			stall_tick <= stall_tick + 1;
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(32, 256);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: steer_stall <= 1'b0;
				1: steer_stall <= ($urandom_range(0, 99) < 30);
				2: steer_stall <= ((stall_tick % 5) < 2);
				default: steer_stall <= ($urandom_range(0, 99) < 80);
			endcase
		end
	end

	always @(posedge clk) begin
		pixel_t seen;
		verdict_t want;
		if (arst_n) begin
			if (pixel_valid && !pixel_stall) begin
				seen.red = red;
				seen.green = green;
				seen.blue = blue;
				seen.eof = end_of_frame;
				track_pixel(seen);
			end
			if (steer_valid && !steer_stall) begin
				if (verdict_q.size() == 0) begin
					flag_mismatch("result beat with none pending", -1, steer_command);
				end else begin
					want = verdict_q.pop_front();
					if (steer_command !== want.cmd)
						flag_mismatch("steer_command", want.cmd, steer_command);
					if (white_count !== want.count)
						flag_mismatch("white_count", want.count, white_count);
				end
			end
		end
	end

	task automatic offer(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
			input logic [CHAN_W-1:0] b, input logic eof);
		pixel_t p;
		p.red = r;
		p.green = g;
		p.blue = b;
		p.eof = eof;
		pixel_q.push_back(p);
		queued_beats++;
	endtask

	task automatic offer_random(input int white_pct, input logic eof);
		int pick;
		logic [CHAN_W-1:0] flip;
		pick = $urandom_range(0, 99);
		flip = 8'h01 << $urandom_range(0, 7);
		if (pick < white_pct) begin
			offer(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL, eof);
		end else if (pick < white_pct + 15) begin
			case ($urandom_range(0, 2))
				0: offer(WHITE_LEVEL ^ flip, WHITE_LEVEL, WHITE_LEVEL, eof);
				1: offer(WHITE_LEVEL, WHITE_LEVEL ^ flip, WHITE_LEVEL, eof);
				default: offer(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL ^ flip, eof);
			endcase
		end else begin
			offer(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), eof);
		end
	endtask

	task automatic offer_frame(input int len, input int white_pct, input bit close);
		for (int i = 0; i < len; i++)
			offer_random(white_pct, close && (i == len - 1));
	endtask

	task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REG_IMAGE_WIDTH) cfg_width = data[WIDTH_W-1:0];
	endtask

	task automatic set_width(input logic [WIDTH_W-1:0] w);
		logic [APB_DW-1:0] word;
		word = $urandom;
		word[WIDTH_W-1:0] = w;
		apb_write(REG_IMAGE_WIDTH, word);
	endtask

	// hold off until every pixel is taken and every verdict has arrived
	task automatic drain();
		int waited;
		waited = 0;
		while ((pixel_q.size() > 0 || pixel_valid || verdict_q.size() > 0)
				&& waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
	endtask

	initial begin : stimulus
		int directed_beats;
		int phase;
		int n;
		int span;
		int len;
		logic [WIDTH_W-1:0] w;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		offer(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL, 1'b0);
		offer(8'h00, 8'h00, 8'h00, 1'b1);
		drain();

		set_width(12'd6);
		for (int i = 0; i < 6; i++)
			offer(i == 3 ? WHITE_LEVEL : 8'h00, i == 3 ? WHITE_LEVEL : 8'h00,
				i == 3 ? WHITE_LEVEL : 8'h00, i == 5);
		for (int i = 0; i < 6; i++)
			offer(i == 5 ? WHITE_LEVEL : 8'h00, i == 5 ? WHITE_LEVEL : 8'h00,
				i == 5 ? WHITE_LEVEL : 8'h00, i == 5);
		offer(8'hFE, 8'hFF, 8'hFF, 1'b0);
		offer(8'hFF, 8'h7F, 8'hFF, 1'b0);
		offer(8'hFF, 8'hFF, 8'hFE, 1'b1);
		for (int i = 0; i < 7; i++)
			offer(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL, i == 6);
		drain();

		set_width(12'd0);
		offer(8'h00, 8'h00, 8'h00, 1'b0);
		offer(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL, 1'b0);
		offer(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL, 1'b1);
		drain();

		set_width(12'd1);
		for (int i = 0; i < 3; i++)
			offer(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL, i == 2);
		drain();

		apb_write(SPARE_REG_ADDR, $urandom);
		set_width(12'd4095);
		directed_beats = queued_beats;

		phase = 0;
		while (queued_beats - directed_beats < RANDOM_BEATS) begin
			case ($urandom_range(0, 9))
				0: w = 12'd1;
				1: w = 12'd2;
				2: w = 12'd3;
				3: w = 12'd4095;
				4: w = 12'd0;
				5: w = WIDTH_RESET;
				default: w = WIDTH_W'($urandom_range(4, 48));
			endcase
			if (phase > 0) set_width(w);
			span = (cfg_width == 0) ? 4 : ((2 * cfg_width + 2 > 160) ? 160 : 2 * cfg_width + 2);
			n = 0;
			while (n < 90) begin
				len = $urandom_range(1, span);
				case ($urandom_range(0, 9))
					0: begin
						len = 8;
						for (int i = 0; i < len; i++)
							offer_random(40, $urandom_range(0, 7) == 0);
					end
					1: offer_frame(len, $urandom_range(0, 100), 1'b0);
					default: offer_frame(len, $urandom_range(10, 70), 1'b1);
				endcase
				n += len;
			end
			if (phase == 2) begin
				for (int i = 0; i < 40; i++)
					offer_frame($urandom_range(1, 3), 50, 1'b1);
				@(posedge clk);
				hold_req <= 1'b1;
			end
			offer_frame($urandom_range(0, 5), 40, 1'b0);
			drain();
			phase++;
		end

		offer_frame(1, 50, 1'b1);
		drain();
		if (mismatches == 0 && verdict_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/wbcs_pkg.sv
rtl/wbcs_cfg.sv
rtl/wbcs_datapath.sv
rtl/wbcs_ctrl.sv
rtl/white_blob_column_steer.sv
test/testbench.sv
